// File: hw/rtl/aots_pkg.sv
// shared types, constants and helpers for the box overlap scan
package aots_pkg;

  localparam int AOTS_DEPTH = 64;
  localparam int SLOT_W     = 6;
  localparam int COORD_W    = 16;
  localparam int EDGE_W     = 18;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef struct packed {
    req_t                       req_type;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic [COORD_W-1:0]         width;
    logic [COORD_W-1:0]         height;
    logic                       solid;
    logic [SLOT_W-1:0]          self_slot;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
  } res_t;

  // rectangle with both edges per axis, far edges at full precision
  typedef struct packed {
    logic signed [EDGE_W-1:0] x1;
    logic signed [EDGE_W-1:0] x2;
    logic signed [EDGE_W-1:0] y1;
    logic signed [EDGE_W-1:0] y2;
  } box_t;

  // scan word handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } tok_t;

  function automatic logic signed [EDGE_W-1:0] near_edge(
    input logic signed [COORD_W-1:0] pos
  );
    near_edge = EDGE_W'(pos);
  endfunction

  function automatic logic signed [EDGE_W-1:0] far_edge(
    input logic signed [COORD_W-1:0] pos,
    input logic [COORD_W-1:0]        len
  );
    logic signed [EDGE_W-1:0] p;
    logic signed [EDGE_W-1:0] l;
    p = EDGE_W'(pos);
    l = $signed({{(EDGE_W-COORD_W){1'b0}}, len});
    far_edge = p + l;
  endfunction

  function automatic box_t make_box(input cmd_t c);
    box_t b;
    b.x1 = near_edge(c.pos_x);
    b.x2 = far_edge(c.pos_x, c.width);
    b.y1 = near_edge(c.pos_y);
    b.y2 = far_edge(c.pos_y, c.height);
    make_box = b;
  endfunction

endpackage

// File: hw/rtl/aots_cell.sv
// one table slot: stored box, solid flag and its stage of the scan chain
module aots_cell
  import aots_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  box_t              wr_box,
  input  logic              wr_solid,
  input  box_t              q_box,
  input  logic              is_self,
  input  logic [SLOT_W-1:0] slot_id,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  box_t box;
  logic solid;
  tok_t tok;
  tok_t tok_next;
  logic touch;

  // inclusive edge tests on both axes
  always_comb begin
    touch = !(box.x2 < q_box.x1) && !(box.x1 > q_box.x2) &&
            !(box.y2 < q_box.y1) && !(box.y1 > q_box.y2);
  end

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.found && solid && !is_self && touch) begin
      tok_next.found = 1'b1;
      tok_next.slot  = slot_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      solid <= 1'b0;
      tok   <= '0;
    end else begin
      if (wr_en) begin
        solid <= wr_solid;
      end
      tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box <= wr_box;
    end
  end

  assign tok_out = tok;

endmodule

// File: hw/rtl/aabb_overlap_table_scan_core.sv
// top level: row of slot cells with a scan word walking down the row
//
//  channel | signals               | handshake
//  --------+-----------------------+-------------------------------------
//  command | start, busy, cmd      | taken on an edge with start & !busy
//  result  | done, res             | one-cycle strobe, always taken
//
// a write: its result strobes the cycle after it is taken
// a query sends a scan word down the row, stepping one cell per cycle
// through TABLE_DEPTH cells, each with its own edge comparators
// reset clears every solid flag and the scan chain
// the receiver cannot stall; a new word may be taken in the done cycle
module aabb_overlap_table_scan_core
  import aots_pkg::*;
#(
  parameter int TABLE_DEPTH = AOTS_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t res
);

  localparam int SLOT_RANGE = 1 << SLOT_W;

  logic accept;
  logic pending;
  logic pending_next;
  logic wr_done;
  logic launch;
  box_t q_box;
  logic [SLOT_W-1:0] q_self;
  box_t wr_box;
  tok_t chain [TABLE_DEPTH+1];
  tok_t last;

  assign accept = start && !busy;
  assign wr_box = make_box(cmd);

  assign chain[0] = '{valid: launch, found: 1'b0, slot: '0};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam bit REACH = (i < SLOT_RANGE);
    logic wr_en;
    logic is_self;

    assign wr_en   = REACH && accept && (cmd.req_type == REQ_WRITE) &&
                     (cmd.slot == SLOT_W'(i));
    assign is_self = REACH && (q_self == SLOT_W'(i));

    aots_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_box   (wr_box),
      .wr_solid (cmd.solid),
      .q_box    (q_box),
      .is_self  (is_self),
      .slot_id  (SLOT_W'(i)),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1])
    );
  end

  assign last = chain[TABLE_DEPTH];

  always_comb begin
    done         = wr_done || last.valid;
    res.hit      = last.valid && last.found;
    res.hit_slot = res.hit ? last.slot : '0;
    busy         = pending && !done;
    pending_next = accept ? 1'b1 : (done ? 1'b0 : pending);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      wr_done <= 1'b0;
      launch  <= 1'b0;
    end else begin
      pending <= pending_next;
      wr_done <= accept && (cmd.req_type == REQ_WRITE);
      launch  <= accept && (cmd.req_type == REQ_QUERY);
    end
  end

  // query box held for the whole walk down the row
  always_ff @(posedge clk) begin
    if (accept && (cmd.req_type == REQ_QUERY)) begin
      q_box  <= wr_box;
      q_self <= cmd.self_slot;
    end
  end

endmodule

// File: hw/rtl/aots_checker.sv
// port-level checks for the overlap scan core and their bind
module aots_checker
  import aots_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic done,
  input res_t res
);

  a_no_hit_zero_slot: assert property (@(posedge clk) disable iff (rst)
    (done && !res.hit) |-> (res.hit_slot == '0))
    else $error("no-hit result with nonzero slot");

  a_taken_then_working: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("word taken but block neither busy nor done");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.req_type == REQ_WRITE) |=> (done && !res.hit))
    else $error("write word without its empty result");

  a_quiet_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !done)
    else $error("result strobe right after reset");

endmodule

bind aabb_overlap_table_scan_core aots_checker u_aots_checker (.*);
